[design/wsdf_pkg.sv]
package wsdf_pkg;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD,
      PH_DEAD
   } phase_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_TOO_LONG   = 2'd0;
   localparam logic [1:0] ERR_FRAG_CTRL  = 2'd1;
   localparam logic [1:0] ERR_CTRL_LONG  = 2'd2;
   localparam logic [1:0] ERR_UNMASKED   = 2'd3;

   localparam logic [6:0]  LEN7_EXT16      = 7'd126;
   localparam logic [6:0]  LEN7_EXT64      = 7'd127;
   localparam logic [3:0]  EXT16_BYTES     = 4'd2;
   localparam logic [3:0]  EXT64_BYTES     = 4'd8;
   localparam logic [3:0]  MASK_BYTES      = 4'd4;
   localparam logic [6:0]  CTRL_MAX_LEN    = 7'd125;
   localparam logic [23:0] MAX_PAYLOAD_RST = 24'd1048576;
   localparam logic [23:0] FLEN_SAT        = 24'hFFFFFF;

endpackage

[design/websocket_frame_deframer_unit.sv]
// Client-to-server WebSocket deframer: one stream byte per req transfer, at most one result
// per byte, registered and shown on rsp in the cycle after the byte is taken. A byte is taken in
// every cycle in which the result register is empty or is being drained, so the sustained rate
// is one byte per clock while rsp_ready is held high. Header bytes, extended length and mask
// key give no result except the header (or error) result on the byte that completes the
// length. After an error result all bytes are taken and dropped until reset.
// max_payload is written through csr (always ready) and applies to frames whose length is
// decoded afterwards. LENGTH_BITS sizes the remaining-byte counter and caps the frame length.
module websocket_frame_deframer_unit #(
   parameter int LENGTH_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_final_flag,
   output logic [23:0] rsp_frame_length,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_max_payload
);
   import wsdf_pkg::*;

   localparam int ACC_W = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
   localparam logic [23:0] LEN_LIMIT =
      (LENGTH_BITS >= 24) ? FLEN_SAT : 24'((64'd1 << LENGTH_BITS) - 64'd1);

   phase_type              phase_ff, phase_in;
   logic [7:0]             hdr_ff, hdr_in;
   logic                   masked_ff, masked_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   over_ff, over_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [7:0]             key_ff [4];
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [1:0]             idx_ff, idx_in;
   logic [23:0]            max_payload_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic [23:0] flen_ff, flen_in;
   logic [1:0]  ecode_ff, ecode_in;
   logic        last_ff, last_in;

   logic        accept;
   logic        emit;
   logic        key_we;
   logic        len_done;
   logic        len_masked;
   logic        len_over;
   logic        hi_nz;
   logic        too_long;
   logic        is_ctrl;
   logic [7:0]  hdr_cur;
   logic [23:0] limit;
   logic [23:0] flen_sat;
   logic [3:0]  cnt_dec;
   logic [6:0]  len7;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign limit = (max_payload_ff > LEN_LIMIT) ? LEN_LIMIT : max_payload_ff;
   assign len7    = req_stream_byte[6:0];
   assign cnt_dec = cnt_ff - 4'd1;

   always_comb begin
      phase_in   = phase_ff;
      hdr_in     = hdr_ff;
      masked_in  = masked_ff;
      acc_in     = acc_ff;
      over_in    = over_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      key_we     = 1'b0;
      len_done   = 1'b0;
      len_masked = masked_ff;
      emit       = 1'b0;
      kind_in    = KIND_HEADER;
      pbyte_in   = '0;
      ecode_in   = ERR_TOO_LONG;
      last_in    = 1'b0;

      unique case (phase_ff)
         PH_FIRST: begin
            hdr_in    = req_stream_byte;
            masked_in = 1'b0;
            acc_in    = '0;
            over_in   = 1'b0;
            phase_in  = PH_SECOND;
         end
         PH_SECOND: begin
            masked_in  = req_stream_byte[7];
            len_masked = req_stream_byte[7];
            acc_in     = '0;
            over_in    = 1'b0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
               cnt_in   = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               acc_in   = ACC_W'(len7);
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            acc_in  = {acc_ff[ACC_W-9:0], req_stream_byte};
            // bits pushed past the accumulator only matter as "too long"
            over_in = over_ff || (acc_ff[ACC_W-1 -: 8] != 8'd0);
            cnt_in  = cnt_dec;
            if (cnt_dec == 4'd0) begin
               len_done = 1'b1;
            end
         end
         PH_MASK: begin
            key_we = 1'b1;
            idx_in = idx_ff + 2'd1;
            cnt_in = cnt_dec;
            if (cnt_dec == 4'd0) begin
               phase_in = (rem_ff == '0) ? PH_FIRST : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            emit     = 1'b1;
            kind_in  = KIND_PAYLOAD;
            pbyte_in = req_stream_byte ^ key_ff[idx_ff];
            idx_in   = idx_ff + 2'd1;
            rem_in   = rem_ff - LENGTH_BITS'(1);
            last_in  = (rem_in == '0);
            if (rem_in == '0) begin
               phase_in = PH_FIRST;
            end
         end
         PH_DEAD: begin
            phase_in = PH_DEAD;
         end
         default: begin
            phase_in = PH_DEAD;
         end
      endcase

      // length complete: check the frame and report header or error
      len_over = over_in;
      hdr_cur  = hdr_ff;
      hi_nz    = len_over || ((acc_in >> 24) != '0);
      flen_sat = hi_nz ? FLEN_SAT : acc_in[23:0];
      too_long = hi_nz || (acc_in > ACC_W'(limit));
      is_ctrl  = hdr_cur[3];
      if (len_done) begin
         emit = 1'b1;
         priority if (too_long) begin
            kind_in  = KIND_ERROR;
            ecode_in = ERR_TOO_LONG;
         end else if (is_ctrl && !hdr_cur[7]) begin
            kind_in  = KIND_ERROR;
            ecode_in = ERR_FRAG_CTRL;
         end else if (is_ctrl && acc_in > ACC_W'(CTRL_MAX_LEN)) begin
            kind_in  = KIND_ERROR;
            ecode_in = ERR_CTRL_LONG;
         end else if (!len_masked) begin
            kind_in  = KIND_ERROR;
            ecode_in = ERR_UNMASKED;
         end else begin
            kind_in  = KIND_HEADER;
         end
         if (kind_in == KIND_ERROR) begin
            last_in  = 1'b1;
            phase_in = PH_DEAD;
         end else begin
            last_in  = (acc_in == '0);
            rem_in   = acc_in[LENGTH_BITS-1:0];
            idx_in   = 2'd0;
            cnt_in   = MASK_BYTES;
            phase_in = PH_MASK;
         end
      end

      opcode_in = hdr_cur[3:0];
      fin_in    = hdr_cur[7];
      flen_in   = flen_sat;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_FIRST;
         hdr_ff         <= '0;
         masked_ff      <= 1'b0;
         acc_ff         <= '0;
         over_ff        <= 1'b0;
         cnt_ff         <= '0;
         rem_ff         <= '0;
         idx_ff         <= '0;
         max_payload_ff <= MAX_PAYLOAD_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            hdr_ff    <= hdr_in;
            masked_ff <= masked_in;
            acc_ff    <= acc_in;
            over_ff   <= over_in;
            cnt_ff    <= cnt_in;
            rem_ff    <= rem_in;
            idx_ff    <= idx_in;
         end
         if (csr_valid && csr_ready) begin
            max_payload_ff <= csr_max_payload;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && key_we) begin
         key_ff[idx_ff] <= req_stream_byte;
      end
      if (accept && emit) begin
         kind_ff   <= kind_in;
         pbyte_ff  <= pbyte_in;
         opcode_ff <= opcode_in;
         fin_ff    <= fin_in;
         flen_ff   <= flen_in;
         ecode_ff  <= (kind_in == KIND_ERROR) ? ecode_in : ERR_TOO_LONG;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = pbyte_ff;
   assign rsp_frame_opcode = opcode_ff;
   assign rsp_final_flag   = fin_ff;
   assign rsp_frame_length = flen_ff;
   assign rsp_error_code   = ecode_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_error_goes_dead: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && kind_in == KIND_ERROR) |=> (phase_ff == PH_DEAD))
      else $error("error result did not stop the parser");

   a_dead_is_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DEAD && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced after an error");

   a_mask_count_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_MASK || phase_ff == PH_EXTLEN) |-> (cnt_ff != 4'd0))
      else $error("byte counter empty inside a counted phase");

   a_last_payload_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_PAYLOAD && last_in) |=> (phase_ff == PH_FIRST))
      else $error("parser did not restart after the last payload byte");

   a_payload_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (rem_ff != '0))
      else $error("payload phase with nothing remaining");
`endif

endmodule

[verif/websocket_frame_deframer_unit_tb.sv]
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_tb;
   import wsdf_pkg::*;

   localparam int          LEN_BITS    = 24;
   localparam logic [63:0] LEN_CAP     = (64'd1 << LEN_BITS) - 64'd1;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          RANDOM_BYTES = 650;
   localparam logic [1:0]  NO_ERROR    = 2'd0;

   typedef enum logic [1:0] {
      ENC_SHORT,
      ENC_EXT16,
      ENC_EXT64
   } len_enc_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [3:0]  opcode;
      logic        fin;
      logic [23:0] length;
      logic [1:0]  err;
      logic        last;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_final_flag;
   logic [23:0] rsp_frame_length;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [23:0] csr_max_payload = 24'd0;

   websocket_frame_deframer_unit #(
      .LENGTH_BITS(LEN_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_frame_opcode(rsp_frame_opcode),
      .rsp_final_flag(rsp_final_flag),
      .rsp_frame_length(rsp_frame_length),
      .rsp_error_code(rsp_error_code),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_max_payload(csr_max_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // pending stream bytes and expected decoder output
   logic [7:0]       tx_q [$];
   frame_result_type expected_results [$];

   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  bytes_queued = 0;
   int  bytes_taken = 0;
   int  cfg_writes = 0;
   int  headers_seen = 0;
   int  payload_seen = 0;
   int  errors_seen = 0;
   int  tx_gap = 0;
   int  rx_gap = 0;
   bit  tx_burst = 1'b0;
   bit  rx_burst = 1'b0;
   logic [23:0] cur_max = MAX_PAYLOAD_RST;

   // deframer prediction state
   phase_type   dp_phase;
   logic [7:0]  dp_hdr;
   logic        dp_masked;
   logic [63:0] dp_len;
   logic [3:0]  dp_count;
   logic [7:0]  dp_key [4];
   logic [23:0] dp_remain;
   logic [1:0]  dp_kidx;
   logic [23:0] dp_max;

   function automatic int imin(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic frame_result_type make_result(logic [1:0] k, logic [7:0] pb,
                                                    logic [63:0] len, logic [1:0] ec,
                                                    logic lst);
      frame_result_type r;
      r.kind         = k;
      r.payload_byte = pb;
      r.opcode       = dp_hdr[3:0];
      r.fin          = dp_hdr[7];
      r.length       = (len > 64'hFFFFFF) ? FLEN_SAT : len[23:0];
      r.err          = ec;
      r.last         = lst;
      return r;
   endfunction

   task automatic expect_result(input frame_result_type r);
      expected_results.insert(expected_results.size(), r);
   endtask

   // length fully decoded: validate the frame, emit header or error
   task automatic finish_length();
      logic [63:0] limit;
      logic [1:0]  ec;
      bit          bad;
      limit = {40'd0, dp_max};
      if (limit > LEN_CAP) limit = LEN_CAP;
      bad = 1'b1;
      ec  = NO_ERROR;
      if (dp_len > limit) ec = ERR_TOO_LONG;
      else if (dp_hdr[3] && !dp_hdr[7]) ec = ERR_FRAG_CTRL;
      else if (dp_hdr[3] && dp_len > 64'(CTRL_MAX_LEN)) ec = ERR_CTRL_LONG;
      else if (!dp_masked) ec = ERR_UNMASKED;
      else bad = 1'b0;
      if (bad) begin
         expect_result(make_result(KIND_ERROR, 8'h00, dp_len, ec, 1'b1));
         dp_phase = PH_DEAD;
      end else begin
         dp_remain = dp_len[23:0];
         dp_kidx   = 2'd0;
         dp_count  = MASK_BYTES;
         dp_phase  = PH_MASK;
         expect_result(make_result(KIND_HEADER, 8'h00, dp_len, NO_ERROR,
                                   dp_len == 64'd0));
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] plain;
      case (dp_phase)
         PH_FIRST: begin
            dp_hdr    = b;
            dp_masked = 1'b0;
            dp_len    = 64'd0;
            dp_phase  = PH_SECOND;
         end
         PH_SECOND: begin
            dp_masked = b[7];
            if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
               dp_count = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               dp_len   = 64'd0;
               dp_phase = PH_EXTLEN;
            end else begin
               dp_len = {57'd0, b[6:0]};
               finish_length();
            end
         end
         PH_EXTLEN: begin
            dp_len   = {dp_len[55:0], b};
            dp_count = dp_count - 4'd1;
            if (dp_count == 4'd0) finish_length();
         end
         PH_MASK: begin
            dp_key[dp_kidx] = b;
            dp_kidx  = dp_kidx + 2'd1;
            dp_count = dp_count - 4'd1;
            if (dp_count == 4'd0) dp_phase = (dp_remain == 24'd0) ? PH_FIRST : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            plain     = b ^ dp_key[dp_kidx];
            dp_kidx   = dp_kidx + 2'd1;
            dp_remain = dp_remain - 24'd1;
            expect_result(make_result(KIND_PAYLOAD, plain, dp_len, NO_ERROR,
                                      dp_remain == 24'd0));
            if (dp_remain == 24'd0) dp_phase = PH_FIRST;
         end
         default: ;
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] b);
      tx_q.insert(tx_q.size(), b);
      bytes_queued++;
   endtask

   function automatic len_enc_type pick_enc(logic [63:0] len);
      int r;
      r = $urandom_range(0, 5);
      if (len <= 64'd125) begin
         if (r < 4) return ENC_SHORT;
         return (r == 4) ? ENC_EXT16 : ENC_EXT64;
      end
      if (len <= 64'd65535) return (r < 4) ? ENC_EXT16 : ENC_EXT64;
      return ENC_EXT64;
   endfunction

   task automatic add_frame(input logic [7:0] h0, input logic m, input len_enc_type enc,
                            input logic [63:0] len, input bit with_body);
      int i;
      queue_byte(h0);
      case (enc)
         ENC_SHORT: queue_byte({m, len[6:0]});
         ENC_EXT16: begin
            queue_byte({m, LEN7_EXT16});
            queue_byte(len[15:8]);
            queue_byte(len[7:0]);
         end
         default: begin
            queue_byte({m, LEN7_EXT64});
            for (i = 7; i >= 0; i--) queue_byte(len[i*8 +: 8]);
         end
      endcase
      if (with_body) begin
         for (i = 0; i < 4; i++) queue_byte(8'($urandom));
         for (i = 0; i < int'(len); i++) queue_byte(8'($urandom));
      end
   endtask

   // frame that passes every check under the current limit (mask bit aside)
   task automatic add_legal_frame(input logic m, input bit with_body);
      logic [7:0] h0;
      int cap;
      int r;
      int len;
      h0 = 8'($urandom);
      if (h0[3]) begin
         h0[7] = 1'b1;
         cap = imin(int'(CTRL_MAX_LEN), int'(cur_max));
      end else begin
         cap = imin(300, int'(cur_max));
      end
      r = $urandom_range(0, 19);
      if (r < 13) len = $urandom_range(0, imin(cap, 12));
      else if (r < 18) len = $urandom_range(0, imin(cap, 60));
      else if (r == 18) len = cap;
      else len = $urandom_range(0, cap);
      add_frame(h0, m, pick_enc(64'(len)), 64'(len), with_body);
   endtask

   // sampled away from the active edge so the driver's updates have settled
   task automatic settle_idle();
      while (tx_q.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(input logic [23:0] v);
      @(posedge clock);
      csr_valid       <= 1'b1;
      csr_max_payload <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dp_max  = v;
      cur_max = v;
      cfg_writes++;
   endtask

   // sender: one byte per transfer, random gap drawn after each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            deframe_byte(req_stream_byte);
            bytes_taken++;
            if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
            tx_gap = tx_burst ? 0 : $urandom_range(0, 17);
         end
         if (!req_valid || req_ready) begin
            if (tx_gap != 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (tx_q.size() != 0) begin
               req_valid       <= 1'b1;
               req_stream_byte <= tx_q[0];
               tx_q.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: check each result transfer, random stall after each one
   frame_result_type rx_got;
   frame_result_type rx_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rx_got = {rsp_kind, rsp_payload_byte, rsp_frame_opcode, rsp_final_flag,
                      rsp_frame_length, rsp_error_code, rsp_last};
            case (rx_got.kind)
               KIND_HEADER:  headers_seen++;
               KIND_PAYLOAD: payload_seen++;
               default:      errors_seen++;
            endcase
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result at cycle %0d: kind %0d byte %02h len %0d",
                           cycle_count, rx_got.kind, rx_got.payload_byte, rx_got.length);
            end else begin
               rx_want = expected_results[0];
               expected_results.delete(0);
               if (rx_got !== rx_want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch at cycle %0d (exp/got): kind %0d/%0d byte %02h/%02h",
                            cycle_count, rx_want.kind, rx_got.kind,
                            rx_want.payload_byte, rx_got.payload_byte);
                     $display(" op %0h/%0h fin %0b/%0b len %0d/%0d err %0d/%0d last %0b/%0b",
                              rx_want.opcode, rx_got.opcode, rx_want.fin, rx_got.fin,
                              rx_want.length, rx_got.length, rx_want.err, rx_got.err,
                              rx_want.last, rx_got.last);
                  end
               end
            end
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
            rx_gap = rx_burst ? 0 : $urandom_range(0, 17);
         end
         if (rx_gap != 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int          rand_start;
      int          phase_end;
      int          i;
      int          pick;
      logic [23:0] v;
      logic [1:0]  final_err;
      logic [7:0]  h0;
      logic [63:0] len;

      dp_phase  = PH_FIRST;
      dp_hdr    = 8'h00;
      dp_masked = 1'b0;
      dp_len    = 64'd0;
      dp_count  = 4'd0;
      for (i = 0; i < 4; i++) dp_key[i] = 8'h00;
      dp_remain = 24'd0;
      dp_kidx   = 2'd0;
      dp_max    = MAX_PAYLOAD_RST;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: zero-length text frame, non-minimal 16-bit length, ping
      @(negedge clock);
      add_frame(8'h81, 1'b1, ENC_SHORT, 64'd0, 1'b1);
      add_frame(8'h02, 1'b1, ENC_EXT16, 64'd3, 1'b0);
      queue_byte(8'hFF); queue_byte(8'h00); queue_byte(8'hA5); queue_byte(8'h5A);
      queue_byte(8'h00); queue_byte(8'hFF); queue_byte(8'hFF);
      add_frame(8'h89, 1'b1, ENC_SHORT, 64'd1, 1'b1);

      // limit of zero: only empty frames pass, 64-bit encoding included
      settle_idle();
      write_max(24'd0);
      @(negedge clock);
      add_frame(8'h8A, 1'b1, ENC_EXT64, 64'd0, 1'b1);
      add_frame(8'hF8, 1'b1, ENC_SHORT, 64'd0, 1'b1);

      // widest limit, control frame at its largest legal length
      settle_idle();
      write_max(FLEN_SAT);
      @(negedge clock);
      add_frame(8'h89, 1'b1, ENC_SHORT, 64'(CTRL_MAX_LEN), 1'b1);
      add_frame(8'h70, 1'b1, ENC_EXT64, 64'd2, 1'b1);

      rand_start = bytes_queued;
      while (bytes_queued - rand_start < RANDOM_BYTES) begin
         // sender holds here until all results are back
         settle_idle();
         pick = $urandom_range(0, 7);
         case (pick)
            0:       v = 24'd0;
            1, 2:    v = FLEN_SAT;
            3:       v = MAX_PAYLOAD_RST;
            4, 5:    v = 24'($urandom_range(0, 40));
            default: v = 24'($urandom_range(126, 400));
         endcase
         write_max(v);
         @(negedge clock);
         phase_end = bytes_queued + $urandom_range(60, 200);
         while (bytes_queued < phase_end) add_legal_frame(1'b1, 1'b1);
      end

      // one protocol error ends the parse; its kind is left to the seed
      settle_idle();
      write_max(($urandom_range(0, 1) == 0) ? FLEN_SAT : 24'($urandom_range(300, 5000)));
      @(negedge clock);
      final_err = 2'($urandom_range(0, 3));
      h0 = 8'($urandom);
      case (final_err)
         ERR_TOO_LONG: begin
            if ($urandom_range(0, 1) == 0) len = 64'(cur_max) + 64'd1;
            else len = {$urandom, $urandom} | (64'd1 << $urandom_range(24, 63));
            add_frame(h0, 1'($urandom), pick_enc(len), len, 1'b0);
         end
         ERR_FRAG_CTRL: begin
            h0[3] = 1'b1;
            h0[7] = 1'b0;
            len = 64'($urandom_range(0, 300));
            add_frame(h0, 1'($urandom), pick_enc(len), len, 1'b0);
         end
         ERR_CTRL_LONG: begin
            h0[3] = 1'b1;
            h0[7] = 1'b1;
            len = 64'($urandom_range(126, imin(int'(cur_max), 4000)));
            add_frame(h0, 1'($urandom), pick_enc(len), len, 1'b0);
         end
         default: add_legal_frame(1'b0, 1'b0);
      endcase
      // parser is dead now, trailing bytes must be dropped silently
      for (i = 0; i < 30; i++) queue_byte(8'($urandom));

      settle_idle();
      repeat (16) @(posedge clock);

      $display("run covered %0d stream bytes over %0d limit settings, error code %0d at the end",
               bytes_taken, cfg_writes + 1, final_err);
      $display("results: %0d headers, %0d payload bytes, %0d errors, %0d left over",
               headers_seen, payload_seen, errors_seen, expected_results.size());
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
